FILE: sv/multi_channel_byte_fifo_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte FIFO table
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BYTE_FIFO_TABLE_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_FIFO_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define MCBF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte fifo table check failed");

// next-cycle implication
`define MCBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte fifo table check failed");

`endif

FILE: sv/mcbf_pkg.sv
// ----------------------------------------------------------------------------
// mcbf_pkg
// Types and constants of the multi-channel byte FIFO table.
// ----------------------------------------------------------------------------
package mcbf_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam int KIND_W = 3;
    localparam int ID_W   = 16;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int FILL_W = 9;

    localparam int FIRST_AUTO_ID = 10;

    localparam logic [KIND_W-1:0] KIND_OPEN_AUTO = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN_ID   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MARK_END  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EOF      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BLOCK    = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   pipe_id;
        logic [BYTE_W-1:0] data_byte;
        logic              transfer_end;
    } in_item_t;

    typedef struct packed {
        in_item_t item;
        logic     bad;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } front_stat_t;

    typedef struct packed {
        logic rd_issue;
        logic rd_wait;
    } back_stat_t;

endpackage

FILE: sv/mcbf_if.sv
// ----------------------------------------------------------------------------
// mcbf channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcbf_in_if;
    import mcbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   pipe_id;
    logic [BYTE_W-1:0] data_byte;
    logic              transfer_end;

    modport source (output valid, kind, pipe_id, data_byte, transfer_end, input ready);
    modport sink   (input valid, kind, pipe_id, data_byte, transfer_end, output ready);
endinterface

interface mcbf_out_if;
    import mcbf_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   assigned_id;
    logic [BYTE_W-1:0] read_byte;
    logic [FILL_W-1:0] fill_level;
    logic              transfer_done;

    modport source (output valid, status, assigned_id, read_byte, fill_level, transfer_done,
                    input ready);
    modport sink   (input valid, status, assigned_id, read_byte, fill_level, transfer_done,
                    output ready);
endinterface

FILE: sv/mcbf_ram.sv
// ----------------------------------------------------------------------------
// mcbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: sv/mcbf_front.sv
// ----------------------------------------------------------------------------
// mcbf_front
// Accept request transfers, flag malformed ones, and hold them in a short queue.
// ----------------------------------------------------------------------------
module mcbf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mcbf_in_if.sink               req,
    input  logic                  pop,
    output mcbf_pkg::cmd_t        head,
    output logic                  head_valid,
    output mcbf_pkg::front_stat_t stat
);
    import mcbf_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          q_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    cmd_t          cmd;
    logic          push;
    logic          do_pop;

    assign req.ready  = (count_reg != CW'(QUEUE_DEPTH));
    assign push       = req.valid && req.ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);

    always_comb
    begin
        cmd.item.kind         = req.kind;
        cmd.item.pipe_id      = req.pipe_id;
        cmd.item.data_byte    = req.data_byte;
        cmd.item.transfer_end = req.transfer_end;
        cmd.bad = (req.kind > KIND_CLOSE)
               || ((req.kind != KIND_OPEN_AUTO) && (req.pipe_id == '0));
    end

    always_comb
    begin
        wr_ptr_next = push   ? QW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (!push && do_pop)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    assign stat.push  = push;
    assign stat.pop   = do_pop;
    assign stat.full  = !req.ready;
    assign stat.empty = (count_reg == '0);
endmodule

FILE: sv/mcbf_back.sv
// ----------------------------------------------------------------------------
// mcbf_back
// Execute queued commands against the channel table and the byte store.
// ----------------------------------------------------------------------------
module mcbf_back #(
    parameter int CHANNEL_SLOTS = mcbf_pkg::SLOTS_DEFAULT,
    parameter int CHANNEL_DEPTH = mcbf_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcbf_pkg::cmd_t       head,
    input  logic                 head_valid,
    output logic                 pop,
    mcbf_out_if.source           rsp,
    output mcbf_pkg::back_stat_t stat
);
    import mcbf_pkg::*;

    localparam int SW    = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
    localparam int IW    = $clog2(CHANNEL_DEPTH);
    localparam int CW    = $clog2(CHANNEL_DEPTH + 1);
    localparam int TOTAL = CHANNEL_SLOTS * CHANNEL_DEPTH;
    localparam int AW    = $clog2(TOTAL);

    typedef enum logic [1:0] {
        S_EXEC  = 2'b01,
        S_RDATA = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [ID_W-1:0] id_reg  [CHANNEL_SLOTS];
    logic [ID_W-1:0] id_next [CHANNEL_SLOTS];
    logic [IW-1:0]   rd_idx_reg  [CHANNEL_SLOTS];
    logic [IW-1:0]   rd_idx_next [CHANNEL_SLOTS];
    logic [IW-1:0]   wr_idx_reg  [CHANNEL_SLOTS];
    logic [IW-1:0]   wr_idx_next [CHANNEL_SLOTS];
    logic [CW-1:0]   cnt_reg  [CHANNEL_SLOTS];
    logic [CW-1:0]   cnt_next [CHANNEL_SLOTS];
    logic [CHANNEL_SLOTS-1:0] eof_reg, eof_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;
    logic              out_done_reg, out_done_next;

    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [FILL_W-1:0] pend_fill_reg, pend_fill_next;
    logic              pend_done_reg, pend_done_next;

    logic [CHANNEL_SLOTS-1:0] hit;
    logic [CHANNEL_SLOTS-1:0] free;
    logic [CHANNEL_SLOTS:0]   used;
    logic                     hit_any, free_any, auto_found;
    logic [SW-1:0]            hit_slot, free_slot;
    logic [ID_W-1:0]          auto_id;
    logic                     out_free;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              rd_issue;
    logic [STAT_W-1:0] st;
    logic [ID_W-1:0]   aid;
    logic [FILL_W-1:0] fl;

    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = 0; i < CHANNEL_SLOTS; i++)
        begin
            hit[i]  = (id_reg[i] == head.item.pipe_id) && (head.item.pipe_id != '0);
            free[i] = (id_reg[i] == '0);
        end
        for (int i = CHANNEL_SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_any  = 1'b1;
                hit_slot = SW'(i);
            end
            if (free[i])
            begin
                free_any  = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    always_comb
    begin
        auto_found = 1'b0;
        auto_id    = ID_W'(FIRST_AUTO_ID);
        for (int k = 0; k <= CHANNEL_SLOTS; k++)
        begin
            used[k] = 1'b0;
            for (int i = 0; i < CHANNEL_SLOTS; i++)
            begin
                if (id_reg[i] == ID_W'(FIRST_AUTO_ID + k))
                begin
                    used[k] = 1'b1;
                end
            end
        end
        for (int k = 0; k <= CHANNEL_SLOTS; k++)
        begin
            if (!auto_found && !used[k])
            begin
                auto_found = 1'b1;
                auto_id    = ID_W'(FIRST_AUTO_ID + k);
            end
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next  = state_reg;
        id_next     = id_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        cnt_next    = cnt_reg;
        eof_next    = eof_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_byte_next   = out_byte_reg;
        out_fill_next   = out_fill_reg;
        out_done_next   = out_done_reg;

        pend_id_next   = pend_id_reg;
        pend_fill_next = pend_fill_reg;
        pend_done_next = pend_done_reg;

        pop       = 1'b0;
        rd_issue  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = AW'(hit_slot) * AW'(CHANNEL_DEPTH) + AW'(wr_idx_reg[hit_slot]);
        ram_raddr = AW'(hit_slot) * AW'(CHANNEL_DEPTH) + AW'(rd_idx_reg[hit_slot]);
        st  = STAT_INVALID;
        aid = head.item.pipe_id;
        fl  = '0;

        unique case (state_reg)
            S_EXEC:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    if (!head.bad)
                    begin
                        case (head.item.kind)
                            KIND_OPEN_AUTO:
                            begin
                                aid = '0;
                                if (!free_any)
                                begin
                                    st = STAT_NO_SPACE;
                                end
                                else
                                begin
                                    id_next[free_slot]     = auto_id;
                                    rd_idx_next[free_slot] = '0;
                                    wr_idx_next[free_slot] = '0;
                                    cnt_next[free_slot]    = '0;
                                    eof_next[free_slot]    = 1'b0;
                                    st  = STAT_OK;
                                    aid = auto_id;
                                end
                            end
                            KIND_OPEN_ID:
                            begin
                                if (free_any && !hit_any)
                                begin
                                    id_next[free_slot]     = head.item.pipe_id;
                                    rd_idx_next[free_slot] = '0;
                                    wr_idx_next[free_slot] = '0;
                                    cnt_next[free_slot]    = '0;
                                    eof_next[free_slot]    = 1'b0;
                                    st = STAT_OK;
                                end
                            end
                            default:
                            begin
                                if (hit_any)
                                begin
                                    fl = FILL_W'(cnt_reg[hit_slot]);
                                    case (head.item.kind)
                                        KIND_WRITE:
                                        begin
                                            if (cnt_reg[hit_slot] >= CW'(CHANNEL_DEPTH))
                                            begin
                                                st = STAT_BLOCK;
                                            end
                                            else
                                            begin
                                                ram_we = 1'b1;
                                                wr_idx_next[hit_slot] =
                                                    (wr_idx_reg[hit_slot] == IW'(CHANNEL_DEPTH - 1))
                                                    ? '0 : IW'(wr_idx_reg[hit_slot] + 1'b1);
                                                cnt_next[hit_slot] = CW'(cnt_reg[hit_slot] + 1'b1);
                                                fl = FILL_W'(cnt_next[hit_slot]);
                                                st = STAT_OK;
                                            end
                                        end
                                        KIND_READ:
                                        begin
                                            if (cnt_reg[hit_slot] == '0)
                                            begin
                                                st = eof_reg[hit_slot] ? STAT_EOF : STAT_BLOCK;
                                            end
                                            else
                                            begin
                                                ram_re   = 1'b1;
                                                rd_issue = 1'b1;
                                                rd_idx_next[hit_slot] =
                                                    (rd_idx_reg[hit_slot] == IW'(CHANNEL_DEPTH - 1))
                                                    ? '0 : IW'(rd_idx_reg[hit_slot] + 1'b1);
                                                cnt_next[hit_slot] = CW'(cnt_reg[hit_slot] - 1'b1);
                                                pend_id_next   = head.item.pipe_id;
                                                pend_fill_next = FILL_W'(cnt_next[hit_slot]);
                                                pend_done_next = head.item.transfer_end;
                                                state_next     = S_RDATA;
                                            end
                                        end
                                        KIND_MARK_END:
                                        begin
                                            eof_next[hit_slot] = 1'b1;
                                            st = STAT_OK;
                                        end
                                        default:
                                        begin
                                            id_next[hit_slot]     = '0;
                                            rd_idx_next[hit_slot] = '0;
                                            wr_idx_next[hit_slot] = '0;
                                            cnt_next[hit_slot]    = '0;
                                            eof_next[hit_slot]    = 1'b0;
                                            fl = '0;
                                            st = STAT_OK;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                    if (!rd_issue)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = st;
                        out_id_next     = aid;
                        out_byte_next   = '0;
                        out_fill_next   = fl;
                        out_done_next   = head.item.transfer_end;
                    end
                end
            end
            S_RDATA:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_id_next     = pend_id_reg;
                    out_byte_next   = ram_rdata;
                    out_fill_next   = pend_fill_reg;
                    out_done_next   = pend_done_reg;
                    state_next      = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            out_valid_reg <= 1'b0;
            eof_reg       <= '0;
            for (int i = 0; i < CHANNEL_SLOTS; i++)
            begin
                id_reg[i]     <= '0;
                rd_idx_reg[i] <= '0;
                wr_idx_reg[i] <= '0;
                cnt_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            eof_reg       <= eof_next;
            id_reg        <= id_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_byte_reg   <= out_byte_next;
        out_fill_reg   <= out_fill_next;
        out_done_reg   <= out_done_next;
        pend_id_reg    <= pend_id_next;
        pend_fill_reg  <= pend_fill_next;
        pend_done_reg  <= pend_done_next;
    end

    mcbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TOTAL)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (head.item.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.assigned_id   = out_id_reg;
    assign rsp.read_byte     = out_byte_reg;
    assign rsp.fill_level    = out_fill_reg;
    assign rsp.transfer_done = out_done_reg;

    assign stat.rd_issue = rd_issue;
    assign stat.rd_wait  = (state_reg == S_RDATA);
endmodule

FILE: sv/multi_channel_byte_fifo_table_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo_table_unit
// Table of byte ring-buffer channels addressed by 16-bit ids.
// ----------------------------------------------------------------------------
// Channels: req carries one command per transfer (open auto id, open given id,
// write byte, read byte, mark end, close); rsp returns exactly one result per
// command, in order. Both use valid/ready; a transfer happens when both are high.
// A command waits in the queue, then executes, and its result is registered;
// a read that returns a byte also waits in S_RDATA for the byte store's
// registered read port.
// Throughput: one command per cycle for all kinds while rsp takes results,
// except a successful read, which also holds the executing side in S_RDATA.
// A two-entry command queue parts the accepting side from the executing side.
// Reset clears the id table, indices, counts and end marks at once; the byte
// store itself is not cleared, and data is only ever read where written.
// When rsp stalls, the result register holds, execution waits, and req keeps
// filling the queue until it is full, then drops ready.
// ----------------------------------------------------------------------------
`include "multi_channel_byte_fifo_table_unit_defines.svh"

module multi_channel_byte_fifo_table_unit #(
    parameter int CHANNEL_SLOTS = mcbf_pkg::SLOTS_DEFAULT,
    parameter int CHANNEL_DEPTH = mcbf_pkg::DEPTH_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    mcbf_in_if.sink    req,
    mcbf_out_if.source rsp
);
    import mcbf_pkg::*;

    cmd_t        head;
    logic        head_valid;
    logic        pop;
    front_stat_t fstat;
    back_stat_t  bstat;

    mcbf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .stat       (fstat)
    );

    mcbf_back #(
        .CHANNEL_SLOTS (CHANNEL_SLOTS),
        .CHANNEL_DEPTH (CHANNEL_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .rsp        (rsp),
        .stat       (bstat)
    );

    `MCBF_ASSERT_SAME(a_pop_nonempty, fstat.pop, !fstat.empty)
    `MCBF_ASSERT_NEXT(a_read_waits, bstat.rd_issue, bstat.rd_wait)
    `MCBF_ASSERT_SAME(a_no_pop_in_wait, bstat.rd_wait, !fstat.pop)
    `MCBF_ASSERT_SAME(a_full_blocks, fstat.full, !fstat.push)
endmodule

FILE: bench/multi_channel_byte_fifo_table_unit_test.sv
// ----------------------------------------------------------------------------
// Byte FIFO table unit test
// Drives open, write, read, mark-end and close commands into the channel table,
// including malformed ids and unused kinds. A local table model predicts every
// result, and each response is compared field by field, in order.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo_table_unit_test;
    import mcbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = SLOTS_DEFAULT;
    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int ITEM_TARGET = 1350;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   assigned_id;
        logic [BYTE_W-1:0] read_byte;
        logic [FILL_W-1:0] fill_level;
        logic              transfer_done;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mcbf_in_if  req ();
    mcbf_out_if rsp ();

    multi_channel_byte_fifo_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [ID_W-1:0]   slot_id [SLOTS];
    int                rd_ptr [SLOTS];
    int                wr_ptr [SLOTS];
    int                count [SLOTS];
    bit                eof_mark [SLOTS];
    logic [BYTE_W-1:0] fifo_mem [SLOTS][DEPTH];
    int                open_count;

    in_item_t pending_q[$];
    answer_t  answer_q[$];
    int       errors = 0;
    int       responses = 0;
    int       sent = 0;
    longint   cycles = 0;
    bit       idle_on = 1'b1;
    bit       hold_send = 1'b0;
    int       send_gap = 0;
    int       take_gap = 0;
    in_item_t it;

    function automatic int slot_of(logic [ID_W-1:0] id);
        if (id == '0)
            return -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < SLOTS; i++)
            if (slot_id[i] == '0)
                return i;
        return -1;
    endfunction

    function automatic answer_t table_step(in_item_t it);
        answer_t a;
        int s;
        int c;
        a.status = STAT_INVALID;
        a.assigned_id = it.pipe_id;
        a.read_byte = '0;
        a.fill_level = '0;
        a.transfer_done = it.transfer_end;
        if (it.kind == KIND_OPEN_AUTO)
        begin
            a.assigned_id = '0;
            s = first_free();
            if (open_count >= SLOTS || s < 0)
                a.status = STAT_NO_SPACE;
            else
            begin
                c = FIRST_AUTO_ID;
                while (slot_of(c[ID_W-1:0]) >= 0)
                    c++;
                slot_id[s] = c[ID_W-1:0];
                rd_ptr[s] = 0; wr_ptr[s] = 0; count[s] = 0; eof_mark[s] = 0;
                open_count++;
                a.status = STAT_OK;
                a.assigned_id = c[ID_W-1:0];
            end
        end
        else if (it.kind == KIND_OPEN_ID)
        begin
            s = first_free();
            if (it.pipe_id == '0 || open_count >= SLOTS)
                a.status = STAT_INVALID;
            else if (s < 0)
                a.status = STAT_NO_SPACE;
            else if (slot_of(it.pipe_id) >= 0)
                a.status = STAT_INVALID;
            else
            begin
                slot_id[s] = it.pipe_id;
                rd_ptr[s] = 0; wr_ptr[s] = 0; count[s] = 0; eof_mark[s] = 0;
                open_count++;
                a.status = STAT_OK;
            end
        end
        else if (it.kind <= KIND_CLOSE)
        begin
            s = slot_of(it.pipe_id);
            if (s >= 0)
            begin
                a.status = STAT_OK;
                case (it.kind)
                    KIND_WRITE:
                        if (count[s] >= DEPTH)
                            a.status = STAT_BLOCK;
                        else
                        begin
                            fifo_mem[s][wr_ptr[s]] = it.data_byte;
                            wr_ptr[s] = (wr_ptr[s] + 1) % DEPTH;
                            count[s]++;
                        end
                    KIND_READ:
                        if (count[s] == 0)
                            a.status = eof_mark[s] ? STAT_EOF : STAT_BLOCK;
                        else
                        begin
                            a.read_byte = fifo_mem[s][rd_ptr[s]];
                            rd_ptr[s] = (rd_ptr[s] + 1) % DEPTH;
                            count[s]--;
                        end
                    KIND_MARK_END:
                        eof_mark[s] = 1'b1;
                    default:
                    begin
                        slot_id[s] = '0;
                        rd_ptr[s] = 0; wr_ptr[s] = 0; count[s] = 0; eof_mark[s] = 0;
                        if (open_count > 0)
                            open_count--;
                    end
                endcase
                a.fill_level = count[s][FILL_W-1:0];
            end
        end
        return a;
    endfunction

    function automatic in_item_t make_item(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                           logic [BYTE_W-1:0] b, logic e);
        in_item_t it;
        it.kind = k;
        it.pipe_id = id;
        it.data_byte = b;
        it.transfer_end = e;
        return it;
    endfunction

    task automatic push(in_item_t it);
        pending_q.push_back(it);
        sent++;
    endtask

    // shadow of the open ids as the stimulus sees them, for picking targets
    logic [ID_W-1:0] gen_ids [SLOTS];

    function automatic logic [ID_W-1:0] pick_gen_id();
        int s;
        s = $urandom_range(SLOTS - 1);
        if (gen_ids[s] != '0 && $urandom_range(11) != 0)
            return gen_ids[s];
        case ($urandom_range(3))
            0: return '0;
            1: return 16'hFFFF;
            2: return ID_W'($urandom);
            default: return ID_W'($urandom_range(24));
        endcase
    endfunction

    initial
    begin
        in_item_t it;
        int burst;
        logic [ID_W-1:0] id;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_id[i] = '0; rd_ptr[i] = 0; wr_ptr[i] = 0; count[i] = 0; eof_mark[i] = 0;
            gen_ids[i] = '0;
            for (int j = 0; j < DEPTH; j++)
                fifo_mem[i][j] = '0;
        end
        open_count = 0;

        push(make_item(KIND_READ, 16'd0, 8'h00, 1'b0));
        push(make_item(KIND_OPEN_ID, 16'd0, 8'h00, 1'b1));
        push(make_item(KIND_OPEN_AUTO, 16'hFFFF, 8'hFF, 1'b0));
        push(make_item(KIND_OPEN_ID, 16'd10, 8'h00, 1'b0));
        push(make_item(KIND_OPEN_ID, 16'hFFFF, 8'h00, 1'b0));
        push(make_item(KIND_OPEN_AUTO, 16'd0, 8'h00, 1'b0));
        push(make_item(KIND_READ, 16'd11, 8'h00, 1'b0));
        push(make_item(KIND_WRITE, 16'd11, 8'h00, 1'b0));
        push(make_item(KIND_WRITE, 16'd11, 8'hFF, 1'b1));
        push(make_item(KIND_WRITE, 16'd1234, 8'hA5, 1'b0));
        push(make_item(KIND_SPARE_LO, 16'd11, 8'h00, 1'b0));
        push(make_item(KIND_SPARE_HI, 16'hFFFF, 8'hFF, 1'b1));
        push(make_item(KIND_MARK_END, 16'd11, 8'h00, 1'b0));
        push(make_item(KIND_READ, 16'd11, 8'h00, 1'b0));
        push(make_item(KIND_READ, 16'd11, 8'h00, 1'b0));
        push(make_item(KIND_READ, 16'd11, 8'h00, 1'b1));
        push(make_item(KIND_CLOSE, 16'd10, 8'h00, 1'b0));
        push(make_item(KIND_CLOSE, 16'd10, 8'h00, 1'b0));
        for (int i = 0; i < 6; i++)
            push(make_item(KIND_OPEN_AUTO, 16'd0, 8'h00, 1'b0));
        push(make_item(KIND_OPEN_AUTO, 16'd0, 8'h00, 1'b0));
        push(make_item(KIND_OPEN_ID, 16'd500, 8'h00, 1'b0));
        push(make_item(KIND_WRITE, 16'd0, 8'h00, 1'b0));
        gen_ids[0] = 16'd10;
        gen_ids[1] = 16'd11;
        gen_ids[2] = 16'hFFFF;
        for (int i = 3; i < SLOTS; i++)
            gen_ids[i] = 16'd12 + i[ID_W-1:0] - 16'd3;

        // fill one channel to capacity, overflow it, then drain past empty
        for (int i = 0; i < DEPTH + 2; i++)
            push(make_item(KIND_WRITE, 16'hFFFF, BYTE_W'($urandom), i == DEPTH + 1));
        for (int i = 0; i < DEPTH + 2; i++)
            push(make_item(KIND_READ, 16'hFFFF, BYTE_W'($urandom), i == DEPTH + 1));

        wait (pending_q.size() == 0 && answer_q.size() == 0 && !req.valid && rst_n);
        hold_send = 1'b1;
        repeat (20) @(posedge clk);
        hold_send = 1'b0;

        while (sent < ITEM_TARGET)
        begin
            wait (pending_q.size() < 16);
            if (sent > ITEM_TARGET - 250)
                idle_on = 1'b0;
            id = pick_gen_id();
            burst = $urandom_range(8, 1);
            case ($urandom_range(15))
                0, 1:
                    push(make_item(KIND_OPEN_AUTO, ID_W'($urandom), BYTE_W'($urandom),
                                   1'($urandom)));
                2, 3:
                    push(make_item(KIND_OPEN_ID,
                                   ($urandom_range(1) != 0) ? ID_W'($urandom_range(30))
                                                            : ID_W'($urandom),
                                   BYTE_W'($urandom), 1'($urandom)));
                4, 5:
                    push(make_item(KIND_CLOSE, id, BYTE_W'($urandom), 1'($urandom)));
                6:
                    push(make_item(KIND_MARK_END, id, BYTE_W'($urandom), 1'($urandom)));
                7:
                    push(make_item(($urandom_range(1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO,
                                   ID_W'($urandom), BYTE_W'($urandom), 1'($urandom)));
                8, 9, 10, 11:
                    for (int i = 0; i < burst; i++)
                        push(make_item(KIND_WRITE, id, BYTE_W'($urandom), i == burst - 1));
                default:
                    for (int i = 0; i < burst; i++)
                        push(make_item(KIND_READ, id, BYTE_W'($urandom), i == burst - 1));
            endcase
            // track which ids the generator believes are open
            for (int i = 0; i < SLOTS; i++)
                if (slot_id[i] != '0)
                    gen_ids[i] = slot_id[i];
        end

        wait (pending_q.size() == 0 && answer_q.size() == 0 && !req.valid);
        repeat (20) @(posedge clk);
        if (answer_q.size() != 0)
        begin
            $error("%0d expected responses never arrived", answer_q.size());
            errors++;
        end
        $display("Covered %0d responses over open, transfer, end-mark and close traffic.",
                 responses);
        $display("Included table full, duplicate ids, id zero, overflow and end of file.");
        if (errors == 0)
            $display("** multi_channel_byte_fifo_table_unit: PASSED **");
        else
            $display("** multi_channel_byte_fifo_table_unit: FAILED **");
        $finish;
    end

    initial
    begin
        req.valid = 1'b0;
        req.kind = '0;
        req.pipe_id = '0;
        req.data_byte = '0;
        req.transfer_end = 1'b0;
        rsp.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** multi_channel_byte_fifo_table_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                it.kind = req.kind;
                it.pipe_id = req.pipe_id;
                it.data_byte = req.data_byte;
                it.transfer_end = req.transfer_end;
                answer_q.push_back(table_step(it));
            end
            if (!(req.valid && !req.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 1'b0;
                end
                else if (!hold_send && pending_q.size() > 0 &&
                         !(idle_on && $urandom_range(9) == 0))
                begin
                    it = pending_q.pop_front();
                    req.valid <= 1'b1;
                    req.kind <= it.kind;
                    req.pipe_id <= it.pipe_id;
                    req.data_byte <= it.data_byte;
                    req.transfer_end <= it.transfer_end;
                end
                else
                begin
                    req.valid <= 1'b0;
                    if (idle_on && $urandom_range(9) == 0)
                        send_gap <= $urandom_range(6, 1) - 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                responses <= responses + 1;
                if (answer_q.size() == 0)
                begin
                    $error("response with nothing expected");
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.assigned_id !== want.assigned_id)
                    begin
                        $error("assigned_id expected %0d actual %0d",
                               want.assigned_id, rsp.assigned_id);
                        errors++;
                    end
                    if (rsp.read_byte !== want.read_byte)
                    begin
                        $error("read_byte expected %0d actual %0d",
                               want.read_byte, rsp.read_byte);
                        errors++;
                    end
                    if (rsp.fill_level !== want.fill_level)
                    begin
                        $error("fill_level expected %0d actual %0d",
                               want.fill_level, rsp.fill_level);
                        errors++;
                    end
                    if (rsp.transfer_done !== want.transfer_done)
                    begin
                        $error("transfer_done expected %0d actual %0d",
                               want.transfer_done, rsp.transfer_done);
                        errors++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap <= take_gap - 1;
                rsp.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(7) == 0)
            begin
                take_gap <= $urandom_range(6, 1) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mcbf_pkg.sv
sv/mcbf_if.sv
sv/mcbf_ram.sv
sv/mcbf_front.sv
sv/mcbf_back.sv
sv/multi_channel_byte_fifo_table_unit.sv
bench/multi_channel_byte_fifo_table_unit_test.sv
